>>> hdl/matrix_multiply_engine_macros.svh
// Assertion macros for the matrix multiply engine.
// Used by the top level only; no other dependencies.
`ifndef MATRIX_MULTIPLY_ENGINE_MACROS_SVH
`define MATRIX_MULTIPLY_ENGINE_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define MME_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mme: same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define MME_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mme: next-cycle check failed");

`endif

>>> hdl/mme_pkg.sv
// Shared types and constants of the matrix multiply engine.
// No dependencies.
package mme_pkg;

  localparam int unsigned MODE_W = 2;
  localparam int unsigned IDX_W  = 3;
  localparam int unsigned ELEM_W = 16;
  localparam int unsigned PROD_W = 40;
  localparam int unsigned MUL_W  = 2 * ELEM_W;

  localparam logic [MODE_W-1:0] MODE_WRITE_A = 2'd0;
  localparam logic [MODE_W-1:0] MODE_WRITE_B = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ    = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_DRAIN
  } ctrl_state_e;

  // Controller to datapath
  typedef struct packed {
    logic accept;  // input word taken this cycle
    logic start;   // read word taken: clear sum, latch indices
    logic issue;   // fetch one A/B pair and step the inner index
    logic load;    // move the finished sum into the output register
  } mme_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic read_req;   // current input word is an in-range read
    logic last_k;     // inner index is at its final value
    logic pipe_busy;  // fetches or products still in flight
    logic out_free;   // output register can take a new word
  } mme_status_t;

endpackage

>>> hdl/mme_in_if.sv
// Input channel of the matrix multiply engine: valid/ready plus one item.
// Depends on mme_pkg.
interface mme_in_if;
  logic                                    valid;
  logic                                    ready;
  logic        [mme_pkg::MODE_W-1:0]       mode;
  logic        [mme_pkg::IDX_W-1:0]        first_index;
  logic        [mme_pkg::IDX_W-1:0]        second_index;
  logic signed [mme_pkg::ELEM_W-1:0]       element_value;

  modport source (output valid, mode, first_index, second_index, element_value,
                  input ready);
  modport sink (input valid, mode, first_index, second_index, element_value,
                output ready);
endinterface

>>> hdl/mme_out_if.sv
// Output channel of the matrix multiply engine: valid/ready plus one result.
// Depends on mme_pkg.
interface mme_out_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [mme_pkg::PROD_W-1:0]       product_value;
  logic        [mme_pkg::IDX_W-1:0]        product_row;
  logic        [mme_pkg::IDX_W-1:0]        product_column;

  modport source (output valid, product_value, product_row, product_column,
                  input ready);
  modport sink (input valid, product_value, product_row, product_column,
                output ready);
endinterface

>>> hdl/matrix_multiply_engine.sv
// Matrix product engine, OUT = A x B, on signed Q8.8 elements. Mode 0 words
// write one element of A at (row, inner index), mode 1 words write one element
// of B at (inner index, column); neither gives a result. A mode
// 2 word asks for OUT(row, column) and returns the exact Q24.16 dot product over
// the inner dimension, with its row and column. A read word keeps the input
// busy until its sum is loaded: one shared multiply-accumulate walks the inner
// index one step a cycle, behind the registered store reads and the product
// register. The result then sits in an output register, so the next word is
// taken while it waits. Out-of-range indices and mode 3 are taken and dropped.
// Store entries must be written before a read uses them; the stores are not
// cleared by reset.
// Depends on mme_pkg, mme_in_if, mme_out_if, mme_ctrl, mme_dp and the macros.
`include "matrix_multiply_engine_macros.svh"

module matrix_multiply_engine #(
  parameter int unsigned ROWS_OUT   = 8,
  parameter int unsigned INNER_SIZE = 8,
  parameter int unsigned COLS_OUT   = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mme_in_if.sink    in_i,
  mme_out_if.source out_o
);

  mme_pkg::mme_cmd_t    cmd;
  mme_pkg::mme_status_t status;

  mme_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .status_i   (status),
    .in_ready_o (in_i.ready),
    .cmd_o      (cmd)
  );

  mme_dp #(
    .ROWS_OUT   (ROWS_OUT),
    .INNER_SIZE (INNER_SIZE),
    .COLS_OUT   (COLS_OUT)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .mode_i           (in_i.mode),
    .first_index_i    (in_i.first_index),
    .second_index_i   (in_i.second_index),
    .element_value_i  (in_i.element_value),
    .out_ready_i      (out_o.ready),
    .out_valid_o      (out_o.valid),
    .product_value_o  (out_o.product_value),
    .product_row_o    (out_o.product_row),
    .product_column_o (out_o.product_column)
  );

  // Input is only open once every fetch and product has drained
  `MME_ASSERT_NOW(a_ready_pipe_empty, clk_i, rst_ni, in_i.ready, !status.pipe_busy)
  // A started read closes the input on the next cycle
  `MME_ASSERT_NEXT(a_start_closes_input, clk_i, rst_ni, cmd.start, !in_i.ready)
  // The sum is moved out only after the last product was added
  `MME_ASSERT_NOW(a_load_after_drain, clk_i, rst_ni, cmd.load, !status.pipe_busy)
  // A loaded sum is presented on the next cycle
  `MME_ASSERT_NEXT(a_load_shows_word, clk_i, rst_ni, cmd.load, out_o.valid)

endmodule

>>> hdl/mme_ctrl.sv
// Controller of the matrix multiply engine: sequences accept, fetch, drain.
// Depends on mme_pkg.
module mme_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  mme_pkg::mme_status_t status_i,
  output logic                 in_ready_o,
  output mme_pkg::mme_cmd_t    cmd_o
);

  mme_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mme_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      mme_pkg::ST_IDLE: begin
        if (in_valid_i && status_i.read_req) begin
          state_d = mme_pkg::ST_FETCH;
        end
      end
      mme_pkg::ST_FETCH: begin
        if (status_i.last_k) begin
          state_d = mme_pkg::ST_DRAIN;
        end
      end
      mme_pkg::ST_DRAIN: begin
        if (!status_i.pipe_busy && status_i.out_free) begin
          state_d = mme_pkg::ST_IDLE;
        end
      end
      default: state_d = mme_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o   = 1'b0;
    cmd_o        = '0;
    case (state_q)
      mme_pkg::ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        cmd_o.start  = in_valid_i && status_i.read_req;
      end
      mme_pkg::ST_FETCH: begin
        cmd_o.issue = 1'b1;
      end
      mme_pkg::ST_DRAIN: begin
        // hold the sum until the output register is free
        cmd_o.load = !status_i.pipe_busy && status_i.out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

>>> hdl/mme_dp.sv
// Datapath of the matrix multiply engine: A and B stores, one shared
// multiply-accumulate and the output register. Depends on mme_pkg.
module mme_dp #(
  parameter int unsigned ROWS_OUT   = 8,
  parameter int unsigned INNER_SIZE = 8,
  parameter int unsigned COLS_OUT   = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  mme_pkg::mme_cmd_t                   cmd_i,
  output mme_pkg::mme_status_t                status_o,
  input  logic        [mme_pkg::MODE_W-1:0]   mode_i,
  input  logic        [mme_pkg::IDX_W-1:0]    first_index_i,
  input  logic        [mme_pkg::IDX_W-1:0]    second_index_i,
  input  logic signed [mme_pkg::ELEM_W-1:0]   element_value_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic signed [mme_pkg::PROD_W-1:0]   product_value_o,
  output logic        [mme_pkg::IDX_W-1:0]    product_row_o,
  output logic        [mme_pkg::IDX_W-1:0]    product_column_o
);

  localparam int unsigned A_DEPTH = ROWS_OUT * INNER_SIZE;
  localparam int unsigned B_DEPTH = INNER_SIZE * COLS_OUT;
  localparam int unsigned A_AW    = (A_DEPTH > 1) ? $clog2(A_DEPTH) : 1;
  localparam int unsigned B_AW    = (B_DEPTH > 1) ? $clog2(B_DEPTH) : 1;
  localparam int unsigned K_W     = (INNER_SIZE > 1) ? $clog2(INNER_SIZE) : 1;
  localparam int unsigned DIM_W   = 9;   // holds sizes up to 256
  localparam int unsigned ADDR_W  = 17;  // holds any full address sum

  logic signed [mme_pkg::ELEM_W-1:0] a_mem [A_DEPTH];
  logic signed [mme_pkg::ELEM_W-1:0] b_mem [B_DEPTH];

  logic        [mme_pkg::IDX_W-1:0]  row_q, col_q;
  logic        [K_W-1:0]             k_q;
  logic signed [mme_pkg::ELEM_W-1:0] a_rd_q, b_rd_q;
  logic                              rd_vld_q, prod_vld_q;
  logic signed [mme_pkg::MUL_W-1:0]  prod_q;
  logic signed [mme_pkg::PROD_W-1:0] acc_q;
  logic                              out_vld_q;
  logic signed [mme_pkg::PROD_W-1:0] out_val_q;
  logic        [mme_pkg::IDX_W-1:0]  out_row_q, out_col_q;

  logic [DIM_W-1:0]  first_ext, second_ext;
  logic              a_in_range, b_in_range, rd_in_range;
  logic              a_we, b_we;
  logic [ADDR_W-1:0] a_wa_full, b_wa_full, a_ra_full, b_ra_full;

  assign first_ext  = DIM_W'(first_index_i);
  assign second_ext = DIM_W'(second_index_i);

  assign a_in_range  = (first_ext < DIM_W'(ROWS_OUT))   && (second_ext < DIM_W'(INNER_SIZE));
  assign b_in_range  = (first_ext < DIM_W'(INNER_SIZE)) && (second_ext < DIM_W'(COLS_OUT));
  assign rd_in_range = (first_ext < DIM_W'(ROWS_OUT))   && (second_ext < DIM_W'(COLS_OUT));

  assign a_we = cmd_i.accept && (mode_i == mme_pkg::MODE_WRITE_A) && a_in_range;
  assign b_we = cmd_i.accept && (mode_i == mme_pkg::MODE_WRITE_B) && b_in_range;

  assign a_wa_full = ADDR_W'(first_index_i) * ADDR_W'(INNER_SIZE) + ADDR_W'(second_index_i);
  assign b_wa_full = ADDR_W'(first_index_i) * ADDR_W'(COLS_OUT) + ADDR_W'(second_index_i);
  assign a_ra_full = ADDR_W'(row_q) * ADDR_W'(INNER_SIZE) + ADDR_W'(k_q);
  assign b_ra_full = ADDR_W'(k_q) * ADDR_W'(COLS_OUT) + ADDR_W'(col_q);

  // Stores: one write and one registered read per cycle each
  always_ff @(posedge clk_i) begin
    if (a_we) begin
      a_mem[a_wa_full[A_AW-1:0]] <= element_value_i;
    end
    a_rd_q <= a_mem[a_ra_full[A_AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (b_we) begin
      b_mem[b_wa_full[B_AW-1:0]] <= element_value_i;
    end
    b_rd_q <= b_mem[b_ra_full[B_AW-1:0]];
  end

  // Indices of the element being built and the inner walk
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      row_q <= first_index_i;
      col_q <= second_index_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q        <= '0;
      rd_vld_q   <= 1'b0;
      prod_vld_q <= 1'b0;
    end else begin
      if (cmd_i.start) begin
        k_q <= '0;
      end else if (cmd_i.issue) begin
        k_q <= k_q + K_W'(1);
      end
      rd_vld_q   <= cmd_i.issue;
      prod_vld_q <= rd_vld_q;
    end
  end

  // Multiply into the product register, then accumulate on the next cycle
  always_ff @(posedge clk_i) begin
    prod_q <= a_rd_q * b_rd_q;
    if (cmd_i.start) begin
      acc_q <= '0;
    end else if (prod_vld_q) begin
      acc_q <= acc_q + mme_pkg::PROD_W'(prod_q);
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_val_q <= acc_q;
      out_row_q <= row_q;
      out_col_q <= col_q;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign product_value_o  = out_val_q;
  assign product_row_o    = out_row_q;
  assign product_column_o = out_col_q;

  assign status_o.read_req  = (mode_i == mme_pkg::MODE_READ) && rd_in_range;
  assign status_o.last_k    = (k_q == K_W'(INNER_SIZE - 1));
  assign status_o.pipe_busy = rd_vld_q || prod_vld_q;
  assign status_o.out_free  = !out_vld_q || out_ready_i;

endmodule
